@@ design/gmw_pkg.sv @@
// ----------------------------------------------------------------------------
// gmw_pkg
// Shared constants, types and constant tables of the geometric mean filter.
// ----------------------------------------------------------------------------
package gmw_pkg;

  localparam int MAX_WIDTH     = 2048;
  localparam int MAX_WINDOW    = 11;
  localparam int LOG_FRAC_BITS = 12;

  localparam int MAX_HEIGHT = 2048;
  localparam int LINE_ROWS  = MAX_WINDOW - 1;
  localparam int NODD       = (MAX_WINDOW + 1) / 2;

  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int N_W     = 4;
  localparam int DIM_W   = 12;
  localparam int CRD_W   = 11;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int SLOT_W  = $clog2(LINE_ROWS);
  localparam int NSEL_W  = (NODD > 1) ? $clog2(NODD) : 1;
  localparam int LOG_W   = 3 + LOG_FRAC_BITS;
  localparam int I_W     = LOG_W - LOG_FRAC_BITS;
  localparam int CSUM_W  = LOG_W + $clog2(MAX_WINDOW);
  localparam int PART_W  = CSUM_W + 2;
  localparam int NGRP    = (MAX_WINDOW + 3) / 4;
  localparam int WSUM_W  = LOG_W + $clog2(MAX_WINDOW * MAX_WINDOW);
  localparam int D_W     = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DIV_SH  = WSUM_W + D_W;
  localparam int RECIP_W = DIV_SH + 1;
  localparam int Y_W     = 31;
  localparam int LANE_LAT = 5 + LOG_FRAC_BITS;

  // configuration register indexes
  localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [N_W-1:0]   WS_RESET = N_W'(5);
  localparam logic [DIM_W-1:0] W_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] H_RESET  = DIM_W'(480);
  localparam logic [CH_W-1:0]  SAT_MAX  = 8'd255;

  localparam longint ONE_Q30   = longint'(1) << 30;
  localparam longint RECIP_ONE = longint'(1) << DIV_SH;

  typedef logic [MAX_WINDOW-1:0][CH_W-1:0] column_t;

  typedef struct packed {
    logic             valid;
    logic             emit;
    logic [CRD_W-1:0] ccol;
    logic [CRD_W-1:0] crow;
    logic             done;
  } meta_t;

  typedef struct packed {
    logic           zero;
    logic [Y_W-1:0] y;
    logic [I_W-1:0] ipart;
  } lane_res_t;

  // ceil(2^DIV_SH / n^2), indexed by the window side
  localparam logic [RECIP_W-1:0] RECIP [16] = '{
    RECIP_W'(RECIP_ONE),
    RECIP_W'((RECIP_ONE + 1 - 1) / 1),
    RECIP_W'((RECIP_ONE + 4 - 1) / 4),
    RECIP_W'((RECIP_ONE + 9 - 1) / 9),
    RECIP_W'((RECIP_ONE + 16 - 1) / 16),
    RECIP_W'((RECIP_ONE + 25 - 1) / 25),
    RECIP_W'((RECIP_ONE + 36 - 1) / 36),
    RECIP_W'((RECIP_ONE + 49 - 1) / 49),
    RECIP_W'((RECIP_ONE + 64 - 1) / 64),
    RECIP_W'((RECIP_ONE + 81 - 1) / 81),
    RECIP_W'((RECIP_ONE + 100 - 1) / 100),
    RECIP_W'((RECIP_ONE + 121 - 1) / 121),
    RECIP_W'((RECIP_ONE + 144 - 1) / 144),
    RECIP_W'((RECIP_ONE + 169 - 1) / 169),
    RECIP_W'((RECIP_ONE + 196 - 1) / 196),
    RECIP_W'((RECIP_ONE + 225 - 1) / 225)
  };

  typedef logic [LOG_W-1:0] log_tab_t [256];
  typedef logic [31:0] root_tab_t [LOG_FRAC_BITS + 1];

  // log2 in Q3.F by repeated squaring of the Q1.30 mantissa
  function automatic log_tab_t build_log_tab();
    log_tab_t    t;
    logic [63:0] x;
    logic [31:0] val;
    int          p;
    for (int v = 0; v < 256; v++) begin
      p = 0;
      for (int b = 0; b < 8; b++) begin
        if (((v >> b) & 1) != 0) p = b;
      end
      x   = 64'(v) << (30 - p);
      val = 32'(p);
      for (int k = 0; k < LOG_FRAC_BITS; k++) begin
        val = val << 1;
        x   = (x * x) >> 30;
        if (x >= 64'(2 * ONE_Q30)) begin
          x   = x >> 1;
          val = val | 32'd1;
        end
      end
      t[v] = (v == 0) ? '0 : LOG_W'(val);
    end
    return t;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] a_in);
    logic [63:0] a;
    logic [63:0] res;
    logic [63:0] bitv;
    a    = a_in;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int s = 0; s < 32; s++) begin
      if (a >= res + bitv) begin
        a   = a - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic root_tab_t build_root_tab();
    root_tab_t r;
    r[0] = 32'(2 * ONE_Q30);
    for (int k = 1; k <= LOG_FRAC_BITS; k++) begin
      r[k] = 32'(floor_sqrt(64'(r[k-1]) << 30));
    end
    return r;
  endfunction

  localparam log_tab_t  LOG_TAB  = build_log_tab();
  localparam root_tab_t ROOT_TAB = build_root_tab();

  // scale the Q1.30 fraction by 2^ipart, truncate, clamp to 8 bits
  function automatic logic [CH_W-1:0] exp_sat(logic [Y_W-1:0] y, logic [I_W-1:0] ipart);
    logic [Y_W+CH_W-1:0] wide;
    logic [Y_W+CH_W-1:0] r;
    wide = {{CH_W{1'b0}}, y} << ipart;
    r    = wide >> 30;
    if (32'(ipart) > 8 || r > (Y_W+CH_W)'(SAT_MAX)) return SAT_MAX;
    return r[CH_W-1:0];
  endfunction

endpackage

@@ design/gmw_pix_if.sv @@
// ----------------------------------------------------------------------------
// gmw_pix_if
// Pixel input channel: valid/ready and one RGB sample per beat.
// ----------------------------------------------------------------------------
interface gmw_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

@@ design/gmw_res_if.sv @@
// ----------------------------------------------------------------------------
// gmw_res_if
// Result channel: filtered pixel and its window center per beat.
// ----------------------------------------------------------------------------
interface gmw_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic [10:0] center_column;
  logic [10:0] center_row;
  logic        frame_done;

  modport source (output valid, red_out, green_out, blue_out, center_column, center_row,
                  frame_done, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, center_column, center_row,
                  frame_done, output ready);
endinterface

@@ design/gmw_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gmw_cfg_if
// Configuration write channel: register index and write data per beat.
// ----------------------------------------------------------------------------
interface gmw_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/gmw_ram.sv @@
// ----------------------------------------------------------------------------
// gmw_ram
// Simple dual-port RAM, one write port, one registered read port (read-first).
// ----------------------------------------------------------------------------
module gmw_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

@@ design/gmw_lane.sv @@
// ----------------------------------------------------------------------------
// gmw_lane
// One color channel: logs, column sums, window sum, mean and exp2 pipeline.
// ----------------------------------------------------------------------------
module gmw_lane (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [gmw_pkg::N_W-1:0] n,
  input  gmw_pkg::column_t        col_in,
  output gmw_pkg::lane_res_t      res
);
  import gmw_pkg::*;

  // stage 1: per-row logs
  logic [LOG_W-1:0]      logs [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] zeros;
  logic                  v1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        logs[k]  <= LOG_TAB[col_in[k]];
        zeros[k] <= (col_in[k] == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  // stage 2: column sums for every odd window height, bottom row up
  logic [CSUM_W-1:0] cs_new [NODD];
  logic [NODD-1:0]   cz_new;

  always_comb begin
    cs_new[0] = CSUM_W'(logs[MAX_WINDOW-1]);
    cz_new[0] = zeros[MAX_WINDOW-1];
    for (int j = 1; j < NODD; j++) begin
      cs_new[j] = cs_new[j-1] + CSUM_W'(logs[MAX_WINDOW-2*j]) + CSUM_W'(logs[MAX_WINDOW-1-2*j]);
      cz_new[j] = cz_new[j-1] | zeros[MAX_WINDOW-2*j] | zeros[MAX_WINDOW-1-2*j];
    end
  end

  logic [CSUM_W-1:0] csum [MAX_WINDOW][NODD];
  logic [NODD-1:0]   cz   [MAX_WINDOW];

  // shift one column in per pixel; newest at the top index
  always_ff @(posedge clk) begin
    if (adv && v1) begin
      for (int c = 0; c < MAX_WINDOW - 1; c++) begin
        csum[c] <= csum[c+1];
        cz[c]   <= cz[c+1];
      end
      csum[MAX_WINDOW-1] <= cs_new;
      cz[MAX_WINDOW-1]   <= cz_new;
    end
  end

  // stage 3: pick height, mask to width, partial sums in groups of four
  logic [NSEL_W-1:0] nsel;
  logic [CSUM_W-1:0] sel  [MAX_WINDOW];
  logic              selz [MAX_WINDOW];
  logic [PART_W-1:0] part_c [NGRP];
  logic [NGRP-1:0]   pz_c;
  logic [PART_W-1:0] part [NGRP];
  logic [NGRP-1:0]   pz;

  assign nsel = NSEL_W'(n >> 1);

  always_comb begin
    for (int c = 0; c < MAX_WINDOW; c++) begin
      if (c + int'(n) >= MAX_WINDOW) begin
        sel[c]  = csum[c][nsel];
        selz[c] = cz[c][nsel];
      end else begin
        sel[c]  = '0;
        selz[c] = 1'b0;
      end
    end
    for (int g = 0; g < NGRP; g++) begin
      part_c[g] = '0;
      pz_c[g]   = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < MAX_WINDOW) begin
          part_c[g] = part_c[g] + PART_W'(sel[4*g+i]);
          pz_c[g]   = pz_c[g] | selz[4*g+i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      part <= part_c;
      pz   <= pz_c;
    end
  end

  // stage 4: window sum
  logic [WSUM_W-1:0] wsum_c;
  logic [WSUM_W-1:0] wsum;
  logic              wz;

  always_comb begin
    wsum_c = '0;
    for (int g = 0; g < NGRP; g++) wsum_c = wsum_c + WSUM_W'(part[g]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wsum <= wsum_c;
      wz   <= |pz;
    end
  end

  // stage 5: divide by n*n through the reciprocal
  logic [WSUM_W+RECIP_W-1:0] prod;
  logic                      pzero;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod  <= (WSUM_W+RECIP_W)'(wsum) * (WSUM_W+RECIP_W)'(RECIP[n]);
      pzero <= wz;
    end
  end

  // exp2 stages: one root multiply per fraction bit
  logic [LOG_W-1:0] m0;
  logic [Y_W-1:0]   ys [1:LOG_FRAC_BITS];
  logic [LOG_W-1:0] ms [1:LOG_FRAC_BITS];
  logic             zs [1:LOG_FRAC_BITS];

  assign m0 = prod[DIV_SH +: LOG_W];

  for (genvar k = 1; k <= LOG_FRAC_BITS; k++) begin : g_exp
    logic [Y_W-1:0]   y_prev;
    logic [LOG_W-1:0] m_prev;
    logic             z_prev;
    logic [2*Y_W-1:0] mul;

    if (k == 1) begin : g_first
      assign y_prev = Y_W'(ONE_Q30);
      assign m_prev = m0;
      assign z_prev = pzero;
    end else begin : g_rest
      assign y_prev = ys[k-1];
      assign m_prev = ms[k-1];
      assign z_prev = zs[k-1];
    end

    assign mul = (2*Y_W)'(y_prev) * (2*Y_W)'(ROOT_TAB[k][Y_W-1:0]);

    always_ff @(posedge clk) begin
      if (adv) begin
        ys[k] <= m_prev[LOG_FRAC_BITS-k] ? mul[30 +: Y_W] : y_prev;
        ms[k] <= m_prev;
        zs[k] <= z_prev;
      end
    end
  end

  assign res.zero  = zs[LOG_FRAC_BITS];
  assign res.y     = ys[LOG_FRAC_BITS];
  assign res.ipart = ms[LOG_FRAC_BITS][LOG_FRAC_BITS +: I_W];
endmodule

@@ design/geometric_mean_window_filter.sv @@
// ----------------------------------------------------------------------------
// geometric_mean_window_filter
// Per-channel geometric mean over an n x n window of an RGB raster stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order while the output is not stalled,
// and gives one result per pixel whose window fits inside the frame; border
// pixels give nothing. Each result passes the lane pipeline (log lookup,
// column sum, two-level window sum, the reciprocal multiply, then one root
// multiply per fraction bit of the mean) and then the output register.
// Line storage is ten single-port-read RAMs of one row each, all read at
// the current column; no clearing pass runs after reset. Write the size
// registers only while no pixel is in flight; a change mid-frame that puts
// the position outside the new frame restarts the frame at (0, 0).
// ----------------------------------------------------------------------------
module geometric_mean_window_filter (
  input  logic         clk,
  input  logic         rst,
  gmw_pix_if.sink      pix,
  gmw_res_if.source    res,
  gmw_cfg_if.sink      cfg
);
  import gmw_pkg::*;

  // configuration registers
  logic [N_W-1:0]   window_size;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= WS_RESET;
      image_width  <= W_RESET;
      image_height <= H_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_WINDOW_SIZE:  window_size  <= cfg.data[N_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg.data;
        REG_IMAGE_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective sizes: odd window, frame clamped to the supported range
  logic [N_W-1:0] n_clip;
  logic [N_W-1:0] n_eff;
  int             w_eff;
  int             h_eff;

  always_comb begin
    if (window_size == '0) n_clip = N_W'(1);
    else if (int'(window_size) > MAX_WINDOW) n_clip = N_W'(MAX_WINDOW);
    else n_clip = window_size;
    if (!n_clip[0]) begin
      n_eff = (int'(n_clip) + 1 > MAX_WINDOW) ? n_clip - N_W'(1) : n_clip + N_W'(1);
    end else begin
      n_eff = n_clip;
    end
    w_eff = (image_width == '0) ? 1 : int'(image_width);
    if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
    h_eff = (image_height == '0) ? 1 : int'(image_height);
    if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
  end

  // whole pipeline moves when the output register is free or being taken
  logic adv;
  logic out_valid;
  logic accept;

  assign adv       = !out_valid || res.ready;
  assign pix.ready = adv;
  assign accept    = pix.valid && adv;

  // raster position
  logic [COL_W-1:0]  col_cnt;
  logic [ROW_W-1:0]  row_cnt;
  logic [SLOT_W-1:0] row_slot;
  logic              wrap;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [SLOT_W-1:0] slot_cur;
  logic              emit_cur;
  logic              done_cur;

  always_comb begin
    wrap     = (int'(col_cnt) >= w_eff) || (int'(row_cnt) >= h_eff);
    col_cur  = wrap ? '0 : col_cnt;
    row_cur  = wrap ? '0 : row_cnt;
    slot_cur = wrap ? '0 : row_slot;
    emit_cur = (int'(row_cur) + 1 >= int'(n_eff)) && (int'(col_cur) + 1 >= int'(n_eff));
    done_cur = (int'(row_cur) + 1 == h_eff) && (int'(col_cur) + 1 == w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt  <= '0;
      row_cnt  <= '0;
      row_slot <= '0;
    end else if (accept) begin
      if (int'(col_cur) + 1 >= w_eff) begin
        col_cnt <= '0;
        if (int'(row_cur) + 1 >= h_eff) begin
          row_cnt  <= '0;
          row_slot <= '0;
        end else begin
          row_cnt  <= row_cur + ROW_W'(1);
          row_slot <= (int'(slot_cur) == LINE_ROWS - 1) ? '0 : slot_cur + SLOT_W'(1);
        end
      end else begin
        col_cnt  <= col_cur + COL_W'(1);
        row_cnt  <= row_cur;
        row_slot <= slot_cur;
      end
    end
  end

  // line buffers: write the current row's slot, read every slot at this column
  logic [PIX_W-1:0]                  pix_word;
  logic [LINE_ROWS-1:0][PIX_W-1:0]   ram_q;

  assign pix_word = {pix.blue_in, pix.green_in, pix.red_in};

  for (genvar r = 0; r < LINE_ROWS; r++) begin : g_line
    gmw_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (accept && (int'(slot_cur) == r)),
      .waddr (col_cur),
      .wdata (pix_word),
      .re    (adv),
      .raddr (col_cur),
      .rdata (ram_q[r])
    );
  end

  // stage 1 beside the RAM read: pixel, slot and result metadata
  meta_t             p1_meta;
  logic [PIX_W-1:0]  p1_pix;
  logic [SLOT_W-1:0] p1_slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_meta.valid <= 1'b0;
      p1_meta.emit  <= 1'b0;
    end else if (adv) begin
      p1_meta.valid <= accept;
      p1_meta.emit  <= accept && emit_cur;
      p1_pix        <= pix_word;
      p1_slot       <= slot_cur;
      p1_meta.ccol  <= CRD_W'(int'(col_cur) - int'(n_eff >> 1));
      p1_meta.crow  <= CRD_W'(int'(row_cur) - int'(n_eff >> 1));
      p1_meta.done  <= done_cur;
    end
  end

  // rotate the line buffer outputs into window rows, oldest first
  column_t col_r;
  column_t col_g;
  column_t col_b;
  int      s_idx;

  always_comb begin
    s_idx = 0;
    for (int k = 0; k < LINE_ROWS; k++) begin
      s_idx = int'(p1_slot) + k;
      if (s_idx >= LINE_ROWS) s_idx = s_idx - LINE_ROWS;
      col_r[k] = ram_q[SLOT_W'(s_idx)][0*CH_W +: CH_W];
      col_g[k] = ram_q[SLOT_W'(s_idx)][1*CH_W +: CH_W];
      col_b[k] = ram_q[SLOT_W'(s_idx)][2*CH_W +: CH_W];
    end
    col_r[MAX_WINDOW-1] = p1_pix[0*CH_W +: CH_W];
    col_g[MAX_WINDOW-1] = p1_pix[1*CH_W +: CH_W];
    col_b[MAX_WINDOW-1] = p1_pix[2*CH_W +: CH_W];
  end

  // channel lanes
  lane_res_t lr;
  lane_res_t lg;
  lane_res_t lb;

  gmw_lane u_lane_r (.clk(clk), .rst(rst), .adv(adv), .in_valid(p1_meta.valid),
                     .n(n_eff), .col_in(col_r), .res(lr));
  gmw_lane u_lane_g (.clk(clk), .rst(rst), .adv(adv), .in_valid(p1_meta.valid),
                     .n(n_eff), .col_in(col_g), .res(lg));
  gmw_lane u_lane_b (.clk(clk), .rst(rst), .adv(adv), .in_valid(p1_meta.valid),
                     .n(n_eff), .col_in(col_b), .res(lb));

  // carry metadata alongside the lanes
  meta_t meta_pipe [LANE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        meta_pipe[i].valid <= 1'b0;
        meta_pipe[i].emit  <= 1'b0;
      end
    end else if (adv) begin
      meta_pipe[0] <= p1_meta;
      for (int i = 1; i < LANE_LAT; i++) meta_pipe[i] <= meta_pipe[i-1];
    end
  end

  // merge: scale, clamp, zero-window override, register the beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= meta_pipe[LANE_LAT-1].emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && meta_pipe[LANE_LAT-1].emit) begin
      res.red_out       <= lr.zero ? '0 : exp_sat(lr.y, lr.ipart);
      res.green_out     <= lg.zero ? '0 : exp_sat(lg.y, lg.ipart);
      res.blue_out      <= lb.zero ? '0 : exp_sat(lb.y, lb.ipart);
      res.center_column <= meta_pipe[LANE_LAT-1].ccol;
      res.center_row    <= meta_pipe[LANE_LAT-1].crow;
      res.frame_done    <= meta_pipe[LANE_LAT-1].done;
    end
  end

  assign res.valid = out_valid;
endmodule

@@ design/gmw_checker.sv @@
// ----------------------------------------------------------------------------
// gmw_checker
// Port-level checks of the geometric mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module gmw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic [10:0] center_column,
  input logic [10:0] center_row,
  input logic        frame_done
);
  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out) &&
    $stable(blue_out) && $stable(center_column) && $stable(center_row) && $stable(frame_done))
    else $error("result beat changed while stalled");

  // an empty output stage never blocks input
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // an output ready to take a result always lets the pipeline advance
  a_ready_taken: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while result is taken");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
endmodule

bind geometric_mean_window_filter gmw_checker u_gmw_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (pix.ready),
  .out_valid     (res.valid),
  .out_ready     (res.ready),
  .red_out       (res.red_out),
  .green_out     (res.green_out),
  .blue_out      (res.blue_out),
  .center_column (res.center_column),
  .center_row    (res.center_row),
  .frame_done    (res.frame_done)
);

@@ test/tb_geometric_mean_window_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_geometric_mean_window_filter
// Self-checking bench for the geometric mean window filter.
// ----------------------------------------------------------------------------
// Streams whole and partial frames of RGB pixels through the filter under
// several window and frame geometries (extremes and out-of-range register
// values included). A bit-exact fixed-point model of the filter predicts
// each result. The scoreboard compares every result beat, field by field,
// with the oldest prediction. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
module tb_geometric_mean_window_filter;
  import gmw_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 40;    // margin beyond the filter pipeline
  localparam int TARGET      = 1200;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [10:0] ccol;
    logic [10:0] crow;
    logic        done;
  } gm_result_t;

  // directed row: pixel plus typed expectations (-1 means use the model)
  typedef struct {
    int r, g, b;
    int er, eg, eb;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  gmw_pix_if pix_bus();
  gmw_res_if res_bus();
  gmw_cfg_if cfg_bus();

  geometric_mean_window_filter uut (
    .clk (clk),
    .rst (rst),
    .pix (pix_bus),
    .res (res_bus),
    .cfg (cfg_bus)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Filter model state
  // --------------------------------------------------------------------------
  logic [3:0]  win_reg;
  logic [11:0] width_reg;
  logic [11:0] height_reg;
  int          col_pos;
  int          row_pos;
  logic [23:0] line_mem [LINE_ROWS][MAX_WIDTH];
  logic [23:0] col_hist [MAX_WINDOW][MAX_WINDOW];  // [column age][row depth]
  logic [14:0] log2_lut [256];
  logic [63:0] root_lut [LOG_FRAC_BITS + 1];

  gm_result_t  pending_q[$];
  int          err_count = 0;
  int          pix_sent;
  int          res_seen = 0;
  int          cycles = 0;
  int          zero_hits;

  // long hold-off: requested by the sender, taken once by the receiver
  bit          calm;
  bit          hold_req;
  bit          hold_taken;
  int          hold_left;

  function automatic logic [63:0] int_sqrt(logic [63:0] a);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= a) root = trial;
    end
    return root;
  endfunction

  // log2 of v in Q3.12, truncated: one fraction bit per squaring of mantissa
  function automatic logic [14:0] log2_q12(int v);
    logic [63:0] mant;
    int          top;
    int          acc;
    top = 0;
    for (int b = 0; b < 8; b++) if (v[b]) top = b;
    mant = 64'(v) << (30 - top);
    acc  = top;
    for (int k = 0; k < LOG_FRAC_BITS; k++) begin
      acc  = acc << 1;
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant = mant >> 1;
        acc  = acc | 1;
      end
    end
    return 15'(acc);
  endfunction

  // 2^(sum / count) truncated and clamped to 8 bits
  function automatic logic [7:0] pow2_mean(logic [63:0] sum, int count);
    logic [63:0] m;
    logic [63:0] y;
    logic [63:0] r;
    int          ip;
    m  = sum / count;
    ip = int'(m >> LOG_FRAC_BITS);
    y  = 64'd1 << 30;
    for (int k = 1; k <= LOG_FRAC_BITS; k++)
      if (m[LOG_FRAC_BITS-k]) y = (y * root_lut[k]) >> 30;
    if (ip > 8) return 8'd255;
    r = (y << ip) >> 30;
    return (r > 255) ? 8'd255 : r[7:0];
  endfunction

  function automatic int eff_window();
    int n;
    n = win_reg;
    if (n < 1) n = 1;
    if (n > MAX_WINDOW) n = MAX_WINDOW;
    if (n % 2 == 0) n = (n + 1 > MAX_WINDOW) ? n - 1 : n + 1;
    return n;
  endfunction

  function automatic int eff_width();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // Advance the model by one accepted pixel; queue a result when the window fits.
  task automatic predict_pixel(logic [23:0] px, int er, int eg, int eb);
    int          n, w, h, row, col, slot;
    logic [63:0] sum;
    bit          has_zero;
    logic [7:0]  v;
    logic [7:0]  mean [3];
    gm_result_t  e;
    n = eff_window();
    w = eff_width();
    h = eff_height();
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    row = row_pos;
    col = col_pos;
    // shift the column history and capture the new column, newest row first
    for (int a = 0; a < MAX_WINDOW - 1; a++) col_hist[a] = col_hist[a+1];
    for (int d = 1; d < MAX_WINDOW; d++) begin
      slot = (row % LINE_ROWS + LINE_ROWS - d) % LINE_ROWS;
      col_hist[MAX_WINDOW-1][d] = line_mem[slot][col];
    end
    col_hist[MAX_WINDOW-1][0] = px;
    line_mem[row % LINE_ROWS][col] = px;

    if (row + 1 >= n && col + 1 >= n) begin
      for (int ch = 0; ch < 3; ch++) begin
        sum      = '0;
        has_zero = 1'b0;
        for (int a = MAX_WINDOW - n; a < MAX_WINDOW; a++)
          for (int d = 0; d < n; d++) begin
            v = col_hist[a][d][8*ch +: 8];
            if (v == 0) has_zero = 1'b1;
            else sum += log2_lut[v];
          end
        mean[ch] = has_zero ? 8'd0 : pow2_mean(sum, n * n);
        if (has_zero) zero_hits++;
      end
      e.red   = (er >= 0) ? 8'(er) : mean[0];
      e.green = (eg >= 0) ? 8'(eg) : mean[1];
      e.blue  = (eb >= 0) ? 8'(eb) : mean[2];
      e.ccol  = 11'(col - n / 2);
      e.crow  = 11'(row - n / 2);
      e.done  = (row + 1 == h && col + 1 == w);
      pending_q.push_back(e);
    end

    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col;
    row_pos = row;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus drivers (inputs change on the falling edge)
  // --------------------------------------------------------------------------
  task automatic send_pixel(logic [23:0] px, int er, int eg, int eb);
    while (!calm && $urandom_range(99) < 25) begin
      pix_bus.valid = 1'b0;
      @(negedge clk);
    end
    pix_bus.valid    = 1'b1;
    pix_bus.red_in   = px[7:0];
    pix_bus.green_in = px[15:8];
    pix_bus.blue_in  = px[23:16];
    @(posedge clk);
    while (!pix_bus.ready) @(posedge clk);
    predict_pixel(px, er, eg, eb);
    pix_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [11:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_WINDOW_SIZE:  win_reg    = data[3:0];
      REG_IMAGE_WIDTH:  width_reg  = data;
      REG_IMAGE_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle.
  task automatic drain();
    pix_bus.valid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_geometry(logic [11:0] n, logic [11:0] w, logic [11:0] h);
    write_reg(REG_WINDOW_SIZE, n);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // zeros, full scale and powers of two show up often; the rest is uniform
  function automatic logic [7:0] rand_chan();
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return 8'd0;
    if (sel < 14) return 8'd255;
    if (sel < 20) return 8'(1 << $urandom_range(7));
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [23:0] rand_pixel();
    return {rand_chan(), rand_chan(), rand_chan()};
  endfunction

  // send whole frames so that the next geometry starts at (0, 0)
  task automatic send_frames(int frames, bit deep_hold, bit mid_pause);
    int total;
    total = frames * eff_width() * eff_height();
    for (int i = 0; i < total; i++) begin
      if (deep_hold && i == 8) hold_req = 1'b1;
      if (mid_pause && i == total / 2) begin
        // hold the sender until the pipe is empty, mid-frame
        pix_bus.valid = 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        @(negedge clk);
      end
      send_pixel(rand_pixel(), -1, -1, -1);
    end
    drain();
  endtask

  // send part of a frame; the next geometry must put the position outside
  // its frame so that the raster restarts at (0, 0)
  task automatic send_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(rand_pixel(), -1, -1, -1);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random back-pressure plus one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      res_bus.ready = 1'b0;
      hold_taken    = 1'b0;
      hold_left     = 0;
    end else if (hold_req && !hold_taken) begin
      hold_left     = 400;
      hold_taken    = 1'b1;
      res_bus.ready = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      res_bus.ready = 1'b0;
    end else begin
      res_bus.ready = calm || ($urandom_range(99) >= 25);
    end
  end

  // Scoreboard: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    gm_result_t e;
    if (!rst && res_bus.valid && res_bus.ready) begin
      res_seen++;
      if (pending_q.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result rgb=%0d,%0d,%0d at (%0d,%0d)", $time,
                 res_bus.red_out, res_bus.green_out, res_bus.blue_out,
                 res_bus.center_row, res_bus.center_column);
      end else begin
        e = pending_q.pop_front();
        if (res_bus.red_out !== e.red || res_bus.green_out !== e.green ||
            res_bus.blue_out !== e.blue || res_bus.center_column !== e.ccol ||
            res_bus.center_row !== e.crow || res_bus.frame_done !== e.done) begin
          err_count++;
          $display("%0t: mismatch expected rgb=%0d,%0d,%0d c=(%0d,%0d) done=%0d", $time,
                   e.red, e.green, e.blue, e.crow, e.ccol, e.done);
          $display("%0t:          actual   rgb=%0d,%0d,%0d c=(%0d,%0d) done=%0d", $time,
                   res_bus.red_out, res_bus.green_out, res_bus.blue_out,
                   res_bus.center_row, res_bus.center_column, res_bus.frame_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding", $time,
               CYCLE_LIMIT, pending_q.size());
      $display("tb_geometric_mean_window_filter: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // n = 1 over an 8 x 3 frame: each result is the pixel through log/exp;
    // zeros and powers of two come back unchanged
    dir_row_t dir_tab [24] = '{
      '{0, 0, 0, 0, 0, 0},             '{255, 255, 255, -1, -1, -1},
      '{1, 1, 1, 1, 1, 1},             '{2, 2, 2, 2, 2, 2},
      '{128, 128, 128, 128, 128, 128}, '{170, 85, 170, -1, -1, -1},
      '{85, 170, 85, -1, -1, -1},      '{0, 255, 1, 0, -1, 1},
      '{255, 0, 128, -1, 0, 128},      '{1, 128, 0, 1, 128, 0},
      '{3, 254, 127, -1, -1, -1},      '{64, 32, 16, 64, 32, 16},
      '{8, 4, 2, 8, 4, 2},             '{200, 100, 50, -1, -1, -1},
      '{254, 253, 252, -1, -1, -1},    '{15, 240, 0, -1, -1, 0},
      '{255, 255, 0, -1, -1, 0},       '{0, 0, 255, 0, 0, -1},
      '{129, 127, 126, -1, -1, -1},    '{1, 255, 1, 1, -1, 1},
      '{7, 63, 191, -1, -1, -1},       '{254, 1, 0, -1, 1, 0},
      '{16, 16, 16, 16, 16, 16},       '{255, 128, 1, -1, 128, 1}
    };
    int phase;
    int n_pick, w_pick, h_pick, nf;

    pix_bus.valid    = 1'b0;
    pix_bus.red_in   = '0;
    pix_bus.green_in = '0;
    pix_bus.blue_in  = '0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = REG_WINDOW_SIZE;
    cfg_bus.data     = '0;
    calm = 1'b0; hold_req = 1'b0;
    pix_sent = 0; zero_hits = 0;

    win_reg = WS_RESET; width_reg = W_RESET; height_reg = H_RESET;
    col_pos = 0; row_pos = 0;
    foreach (line_mem[a, b]) line_mem[a][b] = '0;
    foreach (col_hist[a, b]) col_hist[a][b] = '0;
    log2_lut[0] = '0;
    for (int v = 1; v < 256; v++) log2_lut[v] = log2_q12(v);
    root_lut[0] = 64'd2 << 30;
    for (int k = 1; k <= LOG_FRAC_BITS; k++) root_lut[k] = int_sqrt(root_lut[k-1] << 30);

    repeat (3) @(posedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed frame
    set_geometry(12'd1, 12'd8, 12'd3);
    foreach (dir_tab[i])
      send_pixel({8'(dir_tab[i].b), 8'(dir_tab[i].g), 8'(dir_tab[i].r)},
                 dir_tab[i].er, dir_tab[i].eg, dir_tab[i].eb);
    drain();

    // extremes: largest window on 3 x 3 (nothing) and 11 x 11; smallest frame
    set_geometry(12'd11, 12'd3, 12'd3);
    send_frames(1, 1'b0, 1'b0);
    set_geometry(12'd11, 12'd11, 12'd11);
    send_frames(1, 1'b0, 1'b0);
    set_geometry(12'd0, 12'd0, 12'd0);
    send_frames(3, 1'b0, 1'b0);
    // width 0 clamps to 1, height 4095 to 2048, window 15 to 11
    set_geometry(12'd15, 12'd0, 12'hFFF);
    send_pixels(64);
    // width 4095 clamps to 2048, height 0 to 1, window 0 to 1; the row
    // position lies outside the new frame, so the raster restarts
    set_geometry(12'hFF0, 12'hFFF, 12'd0);
    send_pixels(64);
    set_geometry(12'd10, 12'd2048, 12'd2048 + 12'd0);
    set_geometry(12'd10, 12'd24, 12'd12);
    send_frames(1, 1'b0, 1'b0);

    // random geometries, whole frames each; the first two are fixed so that
    // the long hold-off and the sender pause always see results in flight
    phase = 0;
    while (pix_sent < TARGET) begin
      n_pick = $urandom_range(15);
      if ($urandom_range(3) != 0) begin
        w_pick = $urandom_range(24, 11);
        h_pick = $urandom_range(14, 11);
        if (n_pick > 7) n_pick = $urandom_range(7, 2);
      end else begin
        w_pick = $urandom_range(12);
        h_pick = $urandom_range(8);
      end
      nf = $urandom_range(2, 1);
      if (phase < 2) begin
        n_pick = 3 + 2 * phase;
        w_pick = 24;
        h_pick = 12;
        nf     = 1;
      end
      set_geometry(12'(n_pick) | (12'($urandom_range(255)) << 4) & 12'h000 | 12'(n_pick),
                   12'(w_pick), 12'(h_pick));
      @(posedge clk);
      calm = (phase == 1);
      @(negedge clk);
      send_frames(nf, phase == 0, phase == 1);
      phase++;
    end

    drain();
    $display("Covered %0d pixels and %0d results over %0d geometries (%0d zero windows).",
             pix_sent, res_seen, phase + 8, zero_hits);
    $display("Run took %0d cycles with random stalls on both sides.", cycles);
    if (err_count == 0) begin
      $display("tb_geometric_mean_window_filter: PASS");
    end else begin
      $display("tb_geometric_mean_window_filter: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/gmw_pkg.sv
design/gmw_pix_if.sv
design/gmw_res_if.sv
design/gmw_cfg_if.sv
design/gmw_ram.sv
design/gmw_lane.sv
design/geometric_mean_window_filter.sv
design/gmw_checker.sv
test/tb_geometric_mean_window_filter.sv
